### src/afk_pkg.sv
// Package for the arm forward kinematics unit: widths, limits, CORDIC constants,
// Q30 product helper. No dependencies.
`default_nettype none
package afk_pkg;
  localparam int ANG_W = 18;
  localparam int LEN_W = 20;
  localparam int Q_W = 34;
  localparam int CFG_IDX_W = 2;
  localparam int ATAN_N = 24;

  localparam logic signed [Q_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Q_W+1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [Q_W+1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [Q_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [LEN_W-1:0] BASE_RST = 20'd20775;
  localparam logic [LEN_W-1:0] SHOULDER_RST = 20'd29491;
  localparam logic [LEN_W-1:0] ELBOW_RST = 20'd31457;
  localparam logic [LEN_W-1:0] WRIST_RST = 20'd4588;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOULDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELBOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST = 2'd3;

  localparam logic [0:0] ST_OK = 1'b0;
  localparam logic [0:0] ST_BAD_ANGLE = 1'b1;

  typedef logic signed [Q_W-1:0] q30_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    len_t base;
    len_t shoulder;
    len_t elbow;
    len_t wrist;
  } links_t;

  function automatic logic signed [ANG_W-1:0] limit_of(input int k);
    case (k)
      0: limit_of = 18'sd50613;
      1: limit_of = 18'sd26879;
      2: limit_of = 18'sd49756;
      3: limit_of = 18'sd39175;
      4: limit_of = 18'sd72918;
      5: limit_of = 18'sd47182;
      default: limit_of = 18'sd72918;
    endcase
  endfunction

  function automatic logic [31:0] atan_of(input int i);
    case (i)
      0: atan_of = 32'd843314856;  1: atan_of = 32'd497837829;
      2: atan_of = 32'd263043836;  3: atan_of = 32'd133525158;
      4: atan_of = 32'd67021686;   5: atan_of = 32'd33543515;
      6: atan_of = 32'd16775850;   7: atan_of = 32'd8388437;
      8: atan_of = 32'd4194282;    9: atan_of = 32'd2097149;
      10: atan_of = 32'd1048575;   11: atan_of = 32'd524287;
      12: atan_of = 32'd262143;    13: atan_of = 32'd131071;
      14: atan_of = 32'd65535;     15: atan_of = 32'd32767;
      16: atan_of = 32'd16383;     17: atan_of = 32'd8191;
      18: atan_of = 32'd4095;      19: atan_of = 32'd2047;
      20: atan_of = 32'd1023;      21: atan_of = 32'd511;
      22: atan_of = 32'd255;       default: atan_of = 32'd127;
    endcase
  endfunction

  // Q30 x Q30 -> Q30, round half up
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [2*Q_W-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    qmul = Q_W'(p >>> 30);
  endfunction
endpackage
`default_nettype wire

### src/afk_cordic.sv
// Pipelined CORDIC sine/cosine of one joint angle, one stage per register.
// Depends on afk_pkg.
`default_nettype none
module afk_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [afk_pkg::ANG_W:0] ang,
  output afk_pkg::q30_t sin_o,
  output afk_pkg::q30_t cos_o
);
  import afk_pkg::*;
  localparam int N = (STAGES < ATAN_N) ? STAGES : ATAN_N;

  logic signed [Q_W+1:0] z0;
  logic signed [Q_W+1:0] zr;
  logic neg_nxt;
  q30_t x_r [N+1];
  q30_t y_r [N+1];
  logic signed [Q_W-1:0] z_r [N+1];
  logic neg_r [N+1];

  always_comb begin
    z0 = 36'(ang) <<< 16;
    zr = z0;
    if (zr > PI_Q30) zr = zr - TWO_PI_Q30;
    else if (zr < -PI_Q30) zr = zr + TWO_PI_Q30;
    neg_nxt = 1'b0;
    if (zr > 36'(HALF_PI_Q30)) begin
      zr = zr - PI_Q30;
      neg_nxt = 1'b1;
    end else if (zr < -36'(HALF_PI_Q30)) begin
      zr = zr + PI_Q30;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= Q_W'(zr);
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [Q_W-1:0] ATN = Q_W'(atan_of(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATN;
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign sin_o = neg_r[N] ? -y_r[N] : y_r[N];
  assign cos_o = neg_r[N] ? -x_r[N] : x_r[N];
endmodule
`default_nettype wire

### src/afk_transform.sv
// Pipelined closed-form transform: products of sines and cosines over stages,
// then position terms and output rounding with saturation. Depends on afk_pkg.
`default_nettype none
module afk_transform #(
  parameter int OUT_FRAC = 16
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire afk_pkg::q30_t s1, c1, s2, c2, s4, c4, s5, c5, s6, c6, s23, c23,
  input  wire afk_pkg::links_t links,
  output logic [3:0][2:0][31:0] rows_o
);
  import afk_pkg::*;

  function automatic logic [31:0] sat_rnd(input logic signed [79:0] v, input int sh);
    logic signed [79:0] r;
    r = (v + (80'sd1 <<< (sh - 1))) >>> sh;
    if (r > 80'sd2147483647) sat_rnd = 32'h7FFFFFFF;
    else if (r < -80'sd2147483648) sat_rnd = 32'h80000000;
    else sat_rnd = r[31:0];
  endfunction

  // stage A
  q30_t c4c5_r, c4s5_r, s1c4_r, c1c4_r, s1s4_r, c1s4_r, s23c1_r, s23s1_r, s23c5_r;
  q30_t s23s4_r, c1s2_r, s1s2_r, c23s5_r, s23s5_r, c23c5_r;
  q30_t a_s1, a_c1, a_s5, a_c5, a_s6, a_c6, a_s23, a_c23, a_c2;
  // stage B
  q30_t bA_r, bB_r, bP_r, bQ_r, bR_r, s1s4c5_r, c1s4c5_r, zz_r, c23c1c4_r, c23s1c4_r;
  q30_t s1s4s5_r, c1s4s5_r, s23c1c5_r, s1s23c5_r;
  q30_t b_s1, b_c1, b_s5, b_s6, b_c6, b_s23s4, b_s1s4, b_c1s4, b_c23, b_c2;
  q30_t b_s23c1, b_s23s1, b_c1s2, b_s1s2;
  // stage C
  q30_t c1A_r, s1A_r, c1B_r, s1B_r, cR6_r, sR6_r, s4s6_r, s4c6_r, xz_r, yz_r;
  q30_t cP_r, sP_r, cQ_r, sQ_r;
  q30_t c_s1s4c5, c_c1s4c5, c_s6, c_c6, c_zz, c_c23, c_c2, c_s1s4s5, c_c1s4s5;
  q30_t c_s23c1, c_s23s1, c_c1s2, c_s1s2, e_s23c1, e_s23s1;
  // stage D
  q30_t r00_r, r01_r, r10_r, r11_r, r20_r, r21_r, r12_r, r22_r, zz_d_r;
  logic signed [79:0] p0_r, p1_r, p2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c4c5_r <= qmul(c4, c5);  c4s5_r <= qmul(c4, s5);
      s1c4_r <= qmul(s1, c4);  c1c4_r <= qmul(c1, c4);
      s1s4_r <= qmul(s1, s4);  c1s4_r <= qmul(c1, s4);
      s23c1_r <= qmul(s23, c1); s23s1_r <= qmul(s23, s1);
      s23c5_r <= qmul(s23, c5); s23s4_r <= qmul(s23, s4);
      c1s2_r <= qmul(c1, s2);  s1s2_r <= qmul(s1, s2);
      c23s5_r <= qmul(c23, s5); s23s5_r <= qmul(s23, s5);
      c23c5_r <= qmul(c23, c5);
      a_s1 <= s1; a_c1 <= c1; a_s5 <= s5; a_c5 <= c5; a_s6 <= s6; a_c6 <= c6;
      a_s23 <= s23; a_c23 <= c23; a_c2 <= c2;

      bA_r <= qmul(a_c23, c4c5_r) - s23s5_r;
      bB_r <= qmul(a_c23, c4s5_r) + s23c5_r;
      bP_r <= qmul(a_c23, c1s4_r) + s1c4_r;
      bQ_r <= qmul(a_c23, s1s4_r) - c1c4_r;
      bR_r <= qmul(a_s23, c4c5_r) + c23s5_r;
      s1s4c5_r <= qmul(s1s4_r, a_c5); c1s4c5_r <= qmul(c1s4_r, a_c5);
      zz_r <= c23c5_r - qmul(a_s23, c4s5_r);
      c23c1c4_r <= qmul(a_c23, c1c4_r); c23s1c4_r <= qmul(a_c23, s1c4_r);
      s1s4s5_r <= qmul(s1s4_r, a_s5); c1s4s5_r <= qmul(c1s4_r, a_s5);
      s23c1c5_r <= qmul(s23c1_r, a_c5); s1s23c5_r <= qmul(a_s1, s23c5_r);
      b_s1 <= a_s1; b_c1 <= a_c1; b_s5 <= a_s5; b_s6 <= a_s6; b_c6 <= a_c6;
      b_s23s4 <= s23s4_r; b_s1s4 <= s1s4_r; b_c1s4 <= c1s4_r; b_c23 <= a_c23;
      b_c2 <= a_c2; b_s23c1 <= s23c1_r; b_s23s1 <= s23s1_r;
      b_c1s2 <= c1s2_r; b_s1s2 <= s1s2_r;

      c1A_r <= qmul(b_c1, bA_r); s1A_r <= qmul(b_s1, bA_r);
      c1B_r <= qmul(b_c1, bB_r); s1B_r <= qmul(b_s1, bB_r);
      cR6_r <= qmul(b_c6, bR_r); sR6_r <= qmul(b_s6, bR_r);
      s4s6_r <= qmul(b_s23s4, b_s6); s4c6_r <= qmul(b_s23s4, b_c6);
      xz_r <= qmul(b_s5, c23c1c4_r - b_s1s4);
      yz_r <= qmul(b_s5, c23s1c4_r + b_c1s4);
      cP_r <= qmul(b_c6, bP_r); sP_r <= qmul(b_s6, bP_r);
      cQ_r <= qmul(b_c6, bQ_r); sQ_r <= qmul(b_s6, bQ_r);
      c_s1s4c5 <= s1s4c5_r; c_c1s4c5 <= c1s4c5_r; c_s6 <= b_s6; c_c6 <= b_c6;
      c_zz <= zz_r; c_c23 <= b_c23; c_c2 <= b_c2;
      c_s1s4s5 <= s1s4s5_r; c_c1s4s5 <= c1s4s5_r;
      c_s23c1 <= s23c1c5_r; c_s23s1 <= s1s23c5_r;
      c_c1s2 <= b_c1s2; c_s1s2 <= b_s1s2;
      e_s23c1 <= b_s23c1; e_s23s1 <= b_s23s1;

      r00_r <= qmul(c_c6, c1A_r - c_s1s4c5) - sP_r;
      r01_r <= qmul(c_s6, c_s1s4c5 - c1A_r) - cP_r;
      r10_r <= qmul(c_c6, s1A_r + c_c1s4c5) - sQ_r;
      r11_r <= qmul(c_s6, -s1A_r - c_c1s4c5) - cQ_r;
      r20_r <= -cR6_r + s4s6_r;
      r21_r <= sR6_r + s4c6_r;
      r12_r <= yz_r + c_s23s1;
      r22_r <= xz_r + c_s23c1;
      zz_d_r <= c_zz;
      p0_r <= 80'(c1B_r - c_s1s4s5) * $signed({1'b0, links.wrist})
            + 80'(e_s23c1) * $signed({1'b0, links.elbow})
            + 80'(c_c1s2) * $signed({1'b0, links.shoulder});
      p1_r <= 80'(s1B_r + c_c1s4s5) * $signed({1'b0, links.wrist})
            + 80'(e_s23s1) * $signed({1'b0, links.elbow})
            + 80'(c_s1s2) * $signed({1'b0, links.shoulder});
      p2_r <= (80'($signed({1'b0, links.base})) <<< 30)
            + 80'(c_zz) * $signed({1'b0, links.wrist})
            + 80'(c_c23) * $signed({1'b0, links.elbow})
            + 80'(c_c2) * $signed({1'b0, links.shoulder});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rows_o[0][0] <= sat_rnd(80'(r00_r), 30 - OUT_FRAC);
      rows_o[1][0] <= sat_rnd(80'(r01_r), 30 - OUT_FRAC);
      rows_o[2][0] <= sat_rnd(80'(r22_r), 30 - OUT_FRAC);
      rows_o[3][0] <= sat_rnd(p0_r, 46 - OUT_FRAC);
      rows_o[0][1] <= sat_rnd(80'(r10_r), 30 - OUT_FRAC);
      rows_o[1][1] <= sat_rnd(80'(r11_r), 30 - OUT_FRAC);
      rows_o[2][1] <= sat_rnd(80'(r12_r), 30 - OUT_FRAC);
      rows_o[3][1] <= sat_rnd(p1_r, 46 - OUT_FRAC);
      rows_o[0][2] <= sat_rnd(80'(r20_r), 30 - OUT_FRAC);
      rows_o[1][2] <= sat_rnd(80'(r21_r), 30 - OUT_FRAC);
      rows_o[2][2] <= sat_rnd(80'(zz_d_r), 30 - OUT_FRAC);
      rows_o[3][2] <= sat_rnd(p2_r, 46 - OUT_FRAC);
    end
  end
endmodule
`default_nettype wire

### src/arm_forward_kinematics_unit.sv
// Arm forward kinematics unit, top level: limit check, seven CORDIC pipes,
// transform pipeline, row serializer. Depends on afk_pkg, afk_cordic, afk_transform.
//
// Input: one pose per transfer on in_tdata (seven 18-bit signed angles,
// 2^-14 rad). Output: three row transfers (x, y, z) per valid pose, tlast on
// z; an out-of-limit pose gives one transfer with status 1 and tlast.
// The whole pipeline advances as one unit when its head is free; the row
// serializer takes a new pose only once the last row of the current one is
// accepted, so throughput is set by the single result port. A stall on
// out_tready freezes the pipeline once its last stage holds a pose; no data
// is lost. Reset (rst_n low, synchronous) clears valid bits and loads the
// link length registers with their defaults. cfg_we writes a link length
// at cfg_addr; indexes beyond the list are ignored.
`default_nettype none
module arm_forward_kinematics_unit #(
  parameter int OUT_FRAC_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [127:0] in_tdata,   // joint1_angle .. joint7_angle, 18 bits each
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [127:0] out_tdata,       // normal, sliding, approach, position
  output logic [2:0] out_tuser,         // status, row_index
  output logic out_tlast,
  input  wire logic cfg_we,
  input  wire logic [afk_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [afk_pkg::LEN_W-1:0] cfg_wdata
);
  import afk_pkg::*;
  localparam int NC = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
  localparam int DEPTH = NC + 6;

  links_t links_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      links_r <= '{BASE_RST, SHOULDER_RST, ELBOW_RST, WRIST_RST};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BASE: links_r.base <= cfg_wdata;
        REG_SHOULDER: links_r.shoulder <= cfg_wdata;
        REG_ELBOW: links_r.elbow <= cfg_wdata;
        REG_WRIST: links_r.wrist <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ang_t ang [7];
  logic ok;
  logic signed [ANG_W:0] a23;
  always_comb begin
    ok = 1'b1;
    for (int k = 0; k < 7; k++) begin
      ang[k] = in_tdata[k*ANG_W +: ANG_W];
      if (ang[k] > limit_of(k) || ang[k] < -limit_of(k)) ok = 1'b0;
    end
    a23 = (ANG_W+1)'(ang[1]) + (ANG_W+1)'(ang[2]);
  end

  // serializer: index 0..2 of the row being sent
  logic [1:0] row_r, row_nxt;
  logic busy_r, busy_nxt;
  logic ser_free;
  logic adv;
  logic [DEPTH-1:0] v_r;
  logic [DEPTH-1:0] ok_r;
  logic [3:0][2:0][31:0] rows;
  logic [3:0][2:0][31:0] hold_r;
  logic hold_ok_r;

  assign ser_free = !busy_r || (out_tready && (row_r == 2'd2 || !hold_ok_r));
  assign adv = !v_r[DEPTH-1] || ser_free;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-2:0], in_tvalid};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) ok_r <= {ok_r[DEPTH-2:0], ok};
  end

  q30_t sn [7];
  q30_t cs [7];
  for (genvar k = 0; k < 6; k++) begin : g_cordic
    afk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clk(clk), .en(adv), .ang((ANG_W+1)'(ang[k])), .sin_o(sn[k]), .cos_o(cs[k])
    );
  end

  // joint 2 plus joint 3 may exceed 18 bits: feed the 19-bit sum
  afk_cordic #(.STAGES(CORDIC_STAGES)) u_c23 (
    .clk(clk), .en(adv), .ang(a23), .sin_o(sn[6]), .cos_o(cs[6])
  );

  afk_transform #(.OUT_FRAC(OUT_FRAC_BITS)) u_xf (
    .clk(clk), .en(adv),
    .s1(sn[0]), .c1(cs[0]), .s2(sn[1]), .c2(cs[1]), .s4(sn[3]), .c4(cs[3]),
    .s5(sn[4]), .c5(cs[4]), .s6(sn[5]), .c6(cs[5]), .s23(sn[6]), .c23(cs[6]),
    .links(links_r), .rows_o(rows)
  );

  always_comb begin
    busy_nxt = busy_r;
    row_nxt = row_r;
    if (busy_r && out_tready) begin
      if (row_r == 2'd2 || !hold_ok_r) busy_nxt = 1'b0;
      else row_nxt = row_r + 2'd1;
    end
    if (adv && v_r[DEPTH-1]) begin
      busy_nxt = 1'b1;
      row_nxt = 2'd0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      row_r <= row_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (adv && v_r[DEPTH-1]) begin
      hold_r <= rows;
      hold_ok_r <= ok_r[DEPTH-1];
    end
  end

  logic [31:0] f [4];
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      case (row_r)
        2'd0: f[j] = hold_r[j][0];
        2'd1: f[j] = hold_r[j][1];
        default: f[j] = hold_r[j][2];
      endcase
      if (!hold_ok_r) f[j] = '0;
    end
  end
  assign out_tvalid = busy_r;
  assign out_tdata = {f[3], f[2], f[1], f[0]};
  assign out_tuser = {(hold_ok_r ? row_r : 2'd0), (hold_ok_r ? ST_OK : ST_BAD_ANGLE)};
  assign out_tlast = !hold_ok_r || row_r == 2'd2;

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> row_r != 2'd3) else $error("row out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(row_r)) else $error("row moved in stall");
  a_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_tready && v_r[DEPTH-1]) |-> !in_tready) else $error("overrun");
endmodule
`default_nettype wire
